// File: rtl/core/gpw_pkg.sv
package gpw_pkg;

    // fixed field widths
    localparam int VA_BITS         = 48;
    localparam int PA_BITS         = 52;
    localparam int ROOT_BITS       = 40;
    localparam int LEN_FIELD_BITS  = 32;
    localparam int CHUNK_BITS      = 13;
    localparam int LENGTH_BITS_DEF = 32;

    // configuration port
    localparam int APB_ADDR_BITS   = 4;
    localparam int APB_DATA_BITS   = 64;
    localparam logic REG_TABLE_ROOT = 1'b0;

    // input item modes
    localparam logic MODE_REQUEST = 1'b0;
    localparam logic MODE_ENTRY   = 1'b1;

    // result kinds
    localparam logic [1:0] KIND_READ  = 2'd0;
    localparam logic [1:0] KIND_CHUNK = 2'd1;
    localparam logic [1:0] KIND_FAULT = 2'd2;

    // walk levels
    localparam logic [1:0] LVL_PML4 = 2'd0;
    localparam logic [1:0] LVL_PDPT = 2'd1;
    localparam logic [1:0] LVL_PD   = 2'd2;
    localparam logic [1:0] LVL_PT   = 2'd3;

    typedef struct packed {
        logic                      mode;
        logic [VA_BITS-1:0]        virtual_address;
        logic [LEN_FIELD_BITS-1:0] transfer_length;
        logic                      is_write;
        logic                      kernel_mode;
        logic [63:0]               entry_data;
    } in_item_t;

    typedef struct packed {
        logic [1:0]            result_kind;
        logic [PA_BITS-1:0]    address;
        logic [CHUNK_BITS-1:0] chunk_bytes;
        logic                  perm_write;
        logic                  perm_user;
        logic                  perm_no_exec;
        logic                  fault_present;
        logic                  fault_write;
        logic                  fault_user;
        logic                  last;
    } out_item_t;

    // walk state without the byte count; perms bit0 write, bit1 user, bit2 no-exec
    typedef struct packed {
        logic               active;
        logic [1:0]         level;
        logic [VA_BITS-1:0] va;
        logic               acc_write;
        logic               acc_kernel;
        logic [2:0]         perms;
    } walk_t;

endpackage

// File: rtl/core/gpw_step.sv
module gpw_step
    import gpw_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
)
(
    input  in_item_t               item,
    input  walk_t                  walk,
    input  logic [LENGTH_BITS-1:0] remaining,
    input  logic [ROOT_BITS-1:0]   root,
    output walk_t                  walk_next,
    output logic [LENGTH_BITS-1:0] remaining_next,
    output out_item_t              res0,
    output out_item_t              res1,
    output logic [1:0]             res_count
);

    // table index of a virtual address at a given level
    function automatic logic [8:0] entry_index(input logic [VA_BITS-1:0] va,
                                               input logic [1:0] lvl);
        logic [8:0] idx;
        begin
            case (lvl)
                LVL_PML4: idx = va[47:39];
                LVL_PDPT: idx = va[38:30];
                LVL_PD:   idx = va[29:21];
                LVL_PT:   idx = va[20:12];
                default:  idx = va[47:39];
            endcase
            return idx;
        end
    endfunction

    logic [LENGTH_BITS-1:0] req_len;
    logic [63:0]            e;
    logic [2:0]             bits;
    logic [2:0]             perms_new;
    logic [1:0]             level_inc;
    logic                   done;
    logic [PA_BITS-1:0]     pa;
    logic                   perm_deny;
    logic [CHUNK_BITS-1:0]  room;
    logic [LENGTH_BITS-1:0] room_ext;
    logic [LENGTH_BITS-1:0] chunk_len;
    logic [LENGTH_BITS-1:0] rem_after;
    logic [VA_BITS-1:0]     va_after;
    out_item_t              blank;
    out_item_t              fault_res;

    // entry decode and permission aggregation
    assign req_len   = LENGTH_BITS'(item.transfer_length);
    assign e         = item.entry_data;
    assign bits      = {e[63], e[2], e[1]};
    assign perms_new = (walk.level == LVL_PML4) ? bits
                     : {walk.perms[2] | bits[2], walk.perms[1:0] & bits[1:0]};
    assign level_inc = walk.level + 2'd1;
    assign perm_deny = (walk.acc_write && !perms_new[0]) ||
                       (!walk.acc_kernel && !perms_new[1]);

    // leaf detection and physical address
    always_comb
    begin
        done = 1'b0;
        pa   = '0;
        if (walk.level == LVL_PDPT && e[7])
        begin
            done = 1'b1;
            pa   = {e[51:30], walk.va[29:0]};
        end
        else if (walk.level == LVL_PD && e[7])
        begin
            done = 1'b1;
            pa   = {e[51:21], walk.va[20:0]};
        end
        else if (walk.level == LVL_PT)
        begin
            done = 1'b1;
            pa   = {e[51:12], walk.va[11:0]};
        end
    end

    // chunk bounded by the end of the 4 KB page
    assign room      = CHUNK_BITS'(13'd4096 - {1'b0, walk.va[11:0]});
    assign room_ext  = LENGTH_BITS'(room);
    assign chunk_len = (remaining < room_ext) ? remaining : room_ext;
    assign rem_after = remaining - chunk_len;
    assign va_after  = walk.va + VA_BITS'(CHUNK_BITS'(chunk_len));

    always_comb
    begin
        blank                 = '0;
        fault_res             = '0;
        fault_res.result_kind = KIND_FAULT;
        fault_res.address     = PA_BITS'(walk.va);
        fault_res.fault_write = walk.acc_write;
        fault_res.fault_user  = !walk.acc_kernel;
        fault_res.last        = 1'b1;

        walk_next      = walk;
        remaining_next = remaining;
        res0           = blank;
        res1           = blank;
        res_count      = 2'd0;

        if (item.mode == MODE_REQUEST)
        begin
            // new access, ignored while busy or when empty
            if (!walk.active && req_len != '0)
            begin
                walk_next.active     = 1'b1;
                walk_next.level      = LVL_PML4;
                walk_next.va         = item.virtual_address;
                walk_next.acc_write  = item.is_write;
                walk_next.acc_kernel = item.kernel_mode;
                walk_next.perms      = '0;
                remaining_next       = req_len;
                res0.result_kind     = KIND_READ;
                res0.address         = {root, entry_index(item.virtual_address,
                                                          LVL_PML4), 3'b000};
                res_count            = 2'd1;
            end
        end
        else if (walk.active)
        begin
            res_count = 2'd1;
            if (!e[0])
            begin
                // not present
                res0             = fault_res;
                walk_next.active = 1'b0;
            end
            else if (!done)
            begin
                // descend one level
                walk_next.perms  = perms_new;
                walk_next.level  = level_inc;
                res0.result_kind = KIND_READ;
                res0.address     = {e[51:12], entry_index(walk.va, level_inc), 3'b000};
            end
            else if (perm_deny)
            begin
                walk_next.perms     = perms_new;
                res0                = fault_res;
                res0.fault_present  = 1'b1;
                walk_next.active    = 1'b0;
            end
            else
            begin
                // translated chunk, then next chunk's first read unless finished
                res0.result_kind  = KIND_CHUNK;
                res0.address      = pa;
                res0.chunk_bytes  = CHUNK_BITS'(chunk_len);
                res0.perm_write   = perms_new[0];
                res0.perm_user    = perms_new[1];
                res0.perm_no_exec = perms_new[2];
                res0.last         = (rem_after == '0);
                remaining_next    = rem_after;
                walk_next.va      = va_after;
                walk_next.level   = LVL_PML4;
                if (rem_after == '0)
                begin
                    walk_next.active = 1'b0;
                    walk_next.perms  = perms_new;
                end
                else
                begin
                    walk_next.perms  = '0;
                    res1.result_kind = KIND_READ;
                    res1.address     = {root, entry_index(va_after, LVL_PML4), 3'b000};
                    res_count        = 2'd2;
                end
            end
        end
    end

endmodule

// File: rtl/core/guest_page_walker_with_chunking_core.sv
// channel   | direction | handshake                    | beat
// ----------+-----------+------------------------------+-------------------------------
// item      | in        | item_valid / item_ready      | request or returned table entry
// result    | out       | result_valid / result_ready  | read request, chunk or fault
// apb       | in/out    | psel, penable, pwrite, pready| table_root at byte address 0
//
// an item is registered on acceptance and resolved when the queue has two free slots, one per cycle unless so stalled
// each item yields zero, one or two results into a four-entry result queue
// item_ready drops only when the input register is held and the queue lacks two free slots
// a result stays at the queue head until result_ready takes it
// rst_n clears the walk state, the queue and table_root; queue payload is not reset
module guest_page_walker_with_chunking_core
    import gpw_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     item_valid,
    output logic                     item_ready,
    input  in_item_t                 item,
    output logic                     result_valid,
    input  logic                     result_ready,
    output out_item_t                result,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready
);

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    logic [ROOT_BITS-1:0]   root_reg;
    logic                   in_vld_reg;
    in_item_t               in_data_reg;
    walk_t                  walk_reg;
    walk_t                  walk_next;
    logic [LENGTH_BITS-1:0] remaining_reg;
    logic [LENGTH_BITS-1:0] remaining_next;
    out_item_t              res0;
    out_item_t              res1;
    logic [1:0]             res_count;
    out_item_t              q_mem [QDEPTH];
    logic [QPTR_W-1:0]      head_reg;
    logic [QPTR_W-1:0]      tail_reg;
    logic [QCNT_W-1:0]      count_reg;
    logic [QCNT_W-1:0]      count_next;
    logic                   cfg_wr;
    logic                   process;
    logic                   item_take;
    logic                   pop;
    logic [1:0]             push_n;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[3] == REG_TABLE_ROOT);
    assign prdata = (paddr[3] == REG_TABLE_ROOT) ? APB_DATA_BITS'(root_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            root_reg <= '0;
        else if (cfg_wr)
            root_reg <= pwdata[ROOT_BITS-1:0];
    end

    // handshake and queue control
    assign process      = in_vld_reg && (count_reg <= QCNT_W'(QDEPTH - 2));
    assign item_ready   = !in_vld_reg || process;
    assign item_take    = item_valid && item_ready;
    assign result_valid = (count_reg != '0);
    assign result       = q_mem[head_reg];
    assign pop          = result_valid && result_ready;
    assign push_n       = process ? res_count : 2'd0;
    assign count_next   = count_reg + QCNT_W'(push_n) - QCNT_W'(pop);

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (item_take)
            in_vld_reg <= 1'b1;
        else if (process)
            in_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (item_take)
            in_data_reg <= item;
    end

    // walk step logic
    gpw_step #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_step (
        .item           (in_data_reg),
        .walk           (walk_reg),
        .remaining      (remaining_reg),
        .root           (root_reg),
        .walk_next      (walk_next),
        .remaining_next (remaining_next),
        .res0           (res0),
        .res1           (res1),
        .res_count      (res_count)
    );

    // walk state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            walk_reg      <= '0;
            remaining_reg <= '0;
        end
        else if (process)
        begin
            walk_reg      <= walk_next;
            remaining_reg <= remaining_next;
        end
    end

    // result queue storage
    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
            q_mem[tail_reg] <= res0;
        if (push_n == 2'd2)
            q_mem[tail_reg + QPTR_W'(1)] <= res1;
    end

    // result queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_reg + QPTR_W'(pop);
            tail_reg  <= tail_reg + QPTR_W'(push_n);
            count_reg <= count_next;
        end
    end

    // checks
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QDEPTH))
        else $error("result queue overfilled");

    a_stall_held: assert property (@(posedge clk) disable iff (!rst_n)
        !item_ready |-> in_vld_reg)
        else $error("item stalled with empty input register");

    a_fault_ends_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (process && res_count != 2'd0 && res0.result_kind == KIND_FAULT) |=> !walk_reg.active)
        else $error("walk still active after fault");

    a_chunk_size: assert property (@(posedge clk) disable iff (!rst_n)
        (process && res_count != 2'd0 && res0.result_kind == KIND_CHUNK) |->
        (res0.chunk_bytes != '0 && res0.chunk_bytes <= CHUNK_BITS'(4096)))
        else $error("chunk byte count out of range");

endmodule

// File: verif/tb_guest_page_walker_with_chunking_core.sv
module tb_guest_page_walker_with_chunking_core;
    timeunit 1ns;
    timeprecision 1ps;
    import gpw_pkg::*;

    localparam logic [APB_ADDR_BITS-1:0] ROOT_ADDR = APB_ADDR_BITS'(REG_TABLE_ROOT * 8);

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     item_valid = 1'b0;
    logic                     item_ready;
    in_item_t                 item = '0;
    logic                     result_valid;
    logic                     result_ready = 1'b0;
    out_item_t                result;
    logic                     psel = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite = 1'b0;
    logic [APB_ADDR_BITS-1:0] paddr = '0;
    logic [APB_DATA_BITS-1:0] pwdata = '0;
    logic [APB_DATA_BITS-1:0] prdata;
    logic                     pready;

    // walker state as this bench tracks it
    logic [ROOT_BITS-1:0] root_frame = '0;
    bit                   walk_on = 1'b0;
    logic [1:0]           walk_lvl = LVL_PML4;
    logic [VA_BITS-1:0]   walk_va = '0;
    logic [31:0]          left = '0;
    bit                   acc_wr = 1'b0;
    bit                   acc_kern = 1'b0;
    logic [2:0]           walk_perms = '0;

    out_item_t   pending_results[$];
    bit          no_stall = 1'b0;
    int unsigned errors = 0;
    int unsigned items_taken = 0;
    int unsigned effective_items = 0;
    int unsigned chunk_count = 0;
    int unsigned seen_reads = 0;
    int unsigned seen_chunks = 0;
    int unsigned seen_faults = 0;
    int unsigned root_writes = 0;

    guest_page_walker_with_chunking_core uut (.*);

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // result side stalls at random, about 27 times in 100
    always @(posedge clk)
    begin
        result_ready <= no_stall || ($urandom_range(99) >= 27);
    end

    function automatic out_item_t mk_result(input logic [1:0] kind, input logic [PA_BITS-1:0] addr,
                                            input logic [CHUNK_BITS-1:0] nbytes,
                                            input logic [2:0] perms, input bit fp, input bit fw,
                                            input bit fu, input bit fin);
        out_item_t r;
        r.result_kind   = kind;
        r.address       = addr;
        r.chunk_bytes   = nbytes;
        r.perm_write    = perms[0];
        r.perm_user     = perms[1];
        r.perm_no_exec  = perms[2];
        r.fault_present = fp;
        r.fault_write   = fw;
        r.fault_user    = fu;
        r.last          = fin;
        return r;
    endfunction

    function automatic string fmt_result(input out_item_t r);
        return $sformatf("kind %0d addr %h bytes %0d perm w%b u%b nx%b fault p%b w%b u%b last %b",
                         r.result_kind, r.address, r.chunk_bytes, r.perm_write, r.perm_user,
                         r.perm_no_exec, r.fault_present, r.fault_write, r.fault_user, r.last);
    endfunction

    // byte address of the table entry indexed by the current va at a level
    function automatic logic [PA_BITS-1:0] slot_addr(input logic [PA_BITS-1:0] base,
                                                     input logic [1:0] lvl);
        logic [8:0] idx;
        idx = 9'(walk_va >> (39 - 9 * lvl));
        return base + {idx, 3'b000};
    endfunction

    function automatic void push_fault(input bit present);
        pending_results.push_back(mk_result(KIND_FAULT, {4'h0, walk_va}, '0, '0, present,
                                            acc_wr, !acc_kern, 1'b1));
        walk_on = 1'b0;
    endfunction

    // expected results of one accepted beat, walk state advanced
    function automatic void predict_item(input in_item_t beat);
        logic [63:0]          e;
        logic [2:0]           bits;
        logic [PA_BITS-1:0]   phys;
        logic [12:0]          room;
        logic [31:0]          take;
        bit                   done;
        int unsigned          made;
        made = pending_results.size();
        items_taken++;
        if (beat.mode == MODE_REQUEST)
        begin
            if (!walk_on && beat.transfer_length != '0)
            begin
                walk_va    = beat.virtual_address;
                left       = beat.transfer_length;
                acc_wr     = beat.is_write;
                acc_kern   = beat.kernel_mode;
                walk_on    = 1'b1;
                walk_lvl   = LVL_PML4;
                walk_perms = '0;
                pending_results.push_back(mk_result(KIND_READ,
                    slot_addr({root_frame, 12'h000}, LVL_PML4), '0, '0, 0, 0, 0, 0));
            end
        end
        else if (walk_on)
        begin
            e = beat.entry_data;
            if (!e[0])
                push_fault(1'b0);
            else
            begin
                // write and user are ANDed, no-exec ORed
                bits = {e[63], e[2], e[1]};
                if (walk_lvl == LVL_PML4)
                    walk_perms = bits;
                else
                    walk_perms = {walk_perms[2] | bits[2], walk_perms[1:0] & bits[1:0]};
                done = 1'b1;
                phys = '0;
                if (walk_lvl == LVL_PDPT && e[7])
                    phys = {e[51:30], walk_va[29:0]};
                else if (walk_lvl == LVL_PD && e[7])
                    phys = {e[51:21], walk_va[20:0]};
                else if (walk_lvl == LVL_PT)
                    phys = {e[51:12], walk_va[11:0]};
                else
                    done = 1'b0;

                if (!done)
                begin
                    walk_lvl = walk_lvl + 2'd1;
                    pending_results.push_back(mk_result(KIND_READ,
                        slot_addr({e[51:12], 12'h000}, walk_lvl), '0, '0, 0, 0, 0, 0));
                end
                else if ((acc_wr && !walk_perms[0]) || (!acc_kern && !walk_perms[1]))
                    push_fault(1'b1);
                else
                begin
                    // chunk never crosses a 4 KB boundary
                    room = 13'd4096 - {1'b0, walk_va[11:0]};
                    take = (left < room) ? left : room;
                    left = left - take;
                    walk_va = walk_va + take;
                    chunk_count++;
                    pending_results.push_back(mk_result(KIND_CHUNK, phys, take[12:0],
                                                        walk_perms, 0, 0, 0, left == 0));
                    walk_lvl = LVL_PML4;
                    if (left == 0)
                        walk_on = 1'b0;
                    else
                    begin
                        walk_perms = '0;
                        pending_results.push_back(mk_result(KIND_READ,
                            slot_addr({root_frame, 12'h000}, LVL_PML4), '0, '0, 0, 0, 0, 0));
                    end
                end
            end
        end
        if (pending_results.size() != made)
            effective_items++;
    endfunction

    // compare each result beat with the oldest expectation
    always @(posedge clk)
    begin : result_check
        out_item_t want;
        bit        bad;
        if (rst_n && result_valid && result_ready)
        begin
            case (result.result_kind)
                KIND_READ:  seen_reads++;
                KIND_CHUNK: seen_chunks++;
                KIND_FAULT: seen_faults++;
                default: ;
            endcase
            if (pending_results.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result beat: %s", fmt_result(result));
            end
            else
            begin
                want = pending_results.pop_front();
                bad = (result.result_kind   !== want.result_kind)   ||
                      (result.address       !== want.address)       ||
                      (result.chunk_bytes   !== want.chunk_bytes)   ||
                      (result.perm_write    !== want.perm_write)    ||
                      (result.perm_user     !== want.perm_user)     ||
                      (result.perm_no_exec  !== want.perm_no_exec)  ||
                      (result.fault_present !== want.fault_present) ||
                      (result.fault_write   !== want.fault_write)   ||
                      (result.fault_user    !== want.fault_user)    ||
                      (result.last          !== want.last);
                if (bad)
                begin
                    errors++;
                    if (errors <= 10)
                    begin
                        $display("mismatch at %0t", $realtime);
                        $display("  want %s", fmt_result(want));
                        $display("  got  %s", fmt_result(result));
                    end
                end
            end
        end
    end

    // one input beat; valid stays up when the next beat follows at once
    task automatic send_item(input in_item_t beat);
        item_valid <= 1'b1;
        item <= beat;
        do @(posedge clk); while (!item_ready);
        predict_item(beat);
        if (!no_stall && $urandom_range(99) < 27)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge clk);
        end
    endtask

    task automatic send_request(input logic [VA_BITS-1:0] va, input logic [31:0] len,
                                input bit wr, input bit kern);
        in_item_t beat;
        beat.mode            = MODE_REQUEST;
        beat.virtual_address = va;
        beat.transfer_length = len;
        beat.is_write        = wr;
        beat.kernel_mode     = kern;
        beat.entry_data      = {$urandom, $urandom};
        send_item(beat);
    endtask

    task automatic send_entry(input logic [63:0] e);
        in_item_t beat;
        beat.mode            = MODE_ENTRY;
        beat.virtual_address = VA_BITS'({$urandom, $urandom});
        beat.transfer_length = $urandom;
        beat.is_write        = 1'($urandom_range(1));
        beat.kernel_mode     = 1'($urandom_range(1));
        beat.entry_data      = e;
        send_item(beat);
    endtask

    // table entry with chosen flag bits, everything else random
    function automatic logic [63:0] pte(input bit p, input bit w, input bit u, input bit ps,
                                        input bit nx);
        logic [63:0] e;
        e = {$urandom, $urandom};
        e[0]  = p;
        e[1]  = w;
        e[2]  = u;
        e[7]  = ps;
        e[63] = nx;
        return e;
    endfunction

    // mostly present and permissive, large pages now and then
    function automatic logic [63:0] random_entry(input logic [1:0] lvl);
        bit ps;
        if (lvl == LVL_PDPT)
            ps = $urandom_range(99) < 20;
        else if (lvl == LVL_PD)
            ps = $urandom_range(99) < 30;
        else
            ps = 1'($urandom_range(1));
        return pte($urandom_range(99) >= 3, $urandom_range(99) >= 8, $urandom_range(99) >= 8,
                   ps, 1'($urandom_range(1)));
    endfunction

    function automatic logic [VA_BITS-1:0] pick_va();
        logic [VA_BITS-1:0] va;
        va = VA_BITS'({$urandom, $urandom});
        case ($urandom_range(3))
            2: va[11:0] = 12'hFFF - 12'($urandom_range(40));
            3: va[VA_BITS-1:12] = '1;
            default: ;
        endcase
        return va;
    endfunction

    function automatic logic [31:0] pick_len();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 70)
            return $urandom_range(1, 300);
        else if (r < 90)
            return $urandom_range(1, 9000);
        return $urandom;
    endfunction

    // wait for the walker to drain before touching its register
    task automatic settle();
        item_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // write table_root, then read it back in a second transfer
    task automatic set_root(input logic [APB_DATA_BITS-1:0] value);
        settle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ROOT_ADDR;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        root_frame = value[ROOT_BITS-1:0];
        root_writes++;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata[ROOT_BITS-1:0] !== root_frame)
        begin
            errors++;
            if (errors <= 10)
                $display("table_root read back %h, want %h", prdata[ROOT_BITS-1:0], root_frame);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // one whole access; table entries answer whatever level the walk is at
    task automatic run_access(input logic [VA_BITS-1:0] va, input logic [31:0] len,
                              input bit wr, input bit kern, input int unsigned max_chunks);
        int unsigned chunk_base;
        logic [63:0] e;
        send_request(va, len, wr, kern);
        chunk_base = chunk_count;
        while (walk_on)
        begin
            // a request while busy must be dropped
            if ($urandom_range(99) < 4)
                send_request(pick_va(), pick_len(), 1'($urandom_range(1)),
                             1'($urandom_range(1)));
            e = random_entry(walk_lvl);
            // cut long accesses short with a not-present entry
            if (chunk_count - chunk_base >= max_chunks)
                e[0] = 1'b0;
            send_entry(e);
        end
    endtask

    task automatic test_idle_noise();
        send_entry(pte(1, 1, 1, 0, 0));
        send_request(48'h1234_5678_9ABC, '0, 1'b1, 1'b1);
    endtask

    task automatic test_four_level_walk();
        send_request('0, 32'd1, 1'b0, 1'b1);
        send_request(48'h7FFF_0000_0000, 32'd100, 1'b1, 1'b0);
        send_entry(pte(1, 1, 1, 1, 0));
        send_entry(pte(1, 1, 1, 0, 1));
        send_entry(pte(1, 1, 1, 0, 0));
        send_entry(pte(1, 1, 1, 0, 0));
    endtask

    task automatic test_large_pages();
        send_request(48'h0000_4321_0ABC, 32'd1, 1'b1, 1'b0);
        send_entry(pte(1, 1, 1, 0, 0));
        send_entry(pte(1, 1, 1, 1, 0));
        send_request(48'hABCD_EF12_3456, 32'd200, 1'b0, 1'b0);
        send_entry(pte(1, 1, 1, 0, 0));
        send_entry(pte(1, 1, 1, 0, 1));
        send_entry(pte(1, 0, 1, 1, 0));
    endtask

    task automatic test_faults();
        // not present at the top level
        send_request(48'h8000_0000_1000, 32'd4, 1'b0, 1'b1);
        send_entry(pte(0, 1, 1, 0, 0));
        // write to a read-only 2 MB page
        send_request(48'h0000_0020_0010, 32'd8, 1'b1, 1'b1);
        send_entry(pte(1, 1, 1, 0, 0));
        send_entry(pte(1, 1, 1, 0, 0));
        send_entry(pte(1, 0, 1, 1, 0));
        // user access to a supervisor 1 GB page
        send_request(48'h0040_0000_0000, 32'd8, 1'b0, 1'b0);
        send_entry(pte(1, 1, 1, 0, 0));
        send_entry(pte(1, 1, 0, 1, 1));
    endtask

    // longest length from the top of the space, wraps to zero, then faults
    task automatic test_wrap_long();
        send_request(48'hFFFF_FFFF_FFF0, 32'hFFFF_FFFF, 1'b1, 1'b0);
        send_entry(pte(1, 1, 1, 0, 1));
        send_entry(pte(1, 1, 1, 1, 0));
        send_entry(pte(1, 1, 1, 0, 0));
        send_entry(pte(1, 1, 1, 1, 1));
        send_entry(pte(0, 0, 0, 0, 0));
    endtask

    task automatic test_random_traffic(input int unsigned target, input bit quiet);
        int unsigned goal;
        int unsigned pick;
        no_stall <= quiet;
        goal = effective_items + target;
        while (effective_items < goal)
        begin
            pick = $urandom_range(99);
            if (pick < 6)
                send_entry(random_entry(LVL_PT));
            else if (pick < 10)
                send_request(pick_va(), '0, 1'($urandom_range(1)), 1'($urandom_range(1)));
            else
                run_access(pick_va(), pick_len(), 1'($urandom_range(1)),
                           1'($urandom_range(1)), $urandom_range(1, 4));
        end
    endtask

    initial
    begin : main
        int unsigned drain_wait;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_root({24'hA5A5A5, 40'hFF_FFFF_FFFF});
        test_idle_noise();
        test_four_level_walk();
        test_large_pages();
        test_faults();
        test_wrap_long();

        set_root({$urandom, $urandom});
        test_random_traffic(300, 1'b0);
        set_root('0);
        test_random_traffic(150, 1'b1);
        set_root({24'h0, 8'($urandom_range(255)), $urandom});
        test_random_traffic(200, 1'b0);

        // drain
        item_valid <= 1'b0;
        drain_wait = 0;
        while (pending_results.size() != 0 && drain_wait < 20000)
        begin
            @(posedge clk);
            drain_wait++;
        end
        repeat (8) @(posedge clk);

        $display("covered %0d item beats (%0d acted on) under %0d table_root settings",
                 items_taken, effective_items, root_writes);
        $display("checked %0d reads, %0d chunks, %0d faults; %0d errors, %0d left over",
                 seen_reads, seen_chunks, seen_faults, errors, pending_results.size());
        if (errors == 0 && pending_results.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // hard stop
    initial
    begin
        #4_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
